>>> rtl/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg: shared types and tables for the bidi line reorder block
// Character classes, controller phases, command and status structs,
// classification and mirroring tables.
// ----------------------------------------------------------------------------
package blr_pkg;

  localparam int MAX_CHARS_DEF = 64;

  // base_mode register codes
  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_LTR  = 2'd1;
  localparam logic [1:0] MODE_RTL  = 2'd2;

  // bidi classes; NL and NR mark a neutral whose left neighbor is L or R
  typedef enum logic [3:0] {
    C_L   = 4'd0,
    C_R   = 4'd1,
    C_AL  = 4'd2,
    C_EN  = 4'd3,
    C_ES  = 4'd4,
    C_ET  = 4'd5,
    C_AN  = 4'd6,
    C_CS  = 4'd7,
    C_NSM = 4'd8,
    C_BN  = 4'd9,
    C_B   = 4'd10,
    C_S   = 4'd11,
    C_WS  = 4'd12,
    C_ON  = 4'd13,
    C_NL  = 4'd14,
    C_NR  = 4'd15
  } cls_t;

  // controller phases, also the command to the datapath
  typedef enum logic [5:0] {
    ST_LOAD,
    ST_CLS_RD, ST_CLS_EX,
    ST_BASE,
    ST_LINE,
    ST_FIND_RD, ST_FIND_EX,
    ST_W1_INIT, ST_W1_RD, ST_W1_EX,
    ST_W4_INIT, ST_W4_RD, ST_W4_EX,
    ST_W5_INIT, ST_W5_RD, ST_W5_EX,
    ST_W7_INIT, ST_W7_RD, ST_W7_EX,
    ST_LV_INIT, ST_LV_RD, ST_LV_EX,
    ST_R_INIT, ST_R_SRD, ST_R_SEX,
    ST_X1, ST_X2, ST_X3, ST_X4,
    ST_LDONE,
    ST_NL,
    ST_OUT_INIT, ST_O_RD1, ST_O_RD2, ST_O_EM
  } state_t;

  typedef struct packed {
    state_t op;
    logic   accept;
  } cmd_t;

  typedef struct packed {
    logic at_n;
    logic is_b;
    logic empty;
    logic at_hi;
    logic hi_m1;
    logic lo_p1;
    logic last_elem;
    logic hasodd;
    logic lvl_one;
    logic swap_more;
    logic inrun;
    logic in_level;
  } status_t;

  // class of one codepoint
  function automatic cls_t classify(input logic [20:0] c);
    if (c == 21'h0A) return C_B;
    if (c == 21'h09) return C_S;
    if (c == 21'h20) return C_WS;
    if (c == 21'h00A0) return C_CS;
    if (c == 21'h200E) return C_L;
    if (c == 21'h200F) return C_R;
    if (c == 21'h200C || c == 21'h200D) return C_BN;
    if (c >= 21'h30 && c <= 21'h39) return C_EN;
    if (c == 21'h2B || c == 21'h2D) return C_ES;
    if (c == 21'h23 || c == 21'h24 || c == 21'h25) return C_ET;
    if (c == 21'h2C || c == 21'h2E || c == 21'h3A || c == 21'h2F) return C_CS;
    if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)) return C_L;
    if (c >= 21'h0591 && c <= 21'h05BD) return C_NSM;
    if (c == 21'h05BF || c == 21'h05C1 || c == 21'h05C2 ||
        c == 21'h05C4 || c == 21'h05C5 || c == 21'h05C7) return C_NSM;
    if (c >= 21'h0590 && c <= 21'h05FF) return C_R;
    if (c >= 21'h0660 && c <= 21'h0669) return C_AN;
    if (c >= 21'h0600 && c <= 21'h06FF) return C_AL;
    if (c >= 21'h0750 && c <= 21'h077F) return C_AL;
    if (c < 21'h80) return C_ON;
    return C_L;
  endfunction

  // mirrored glyph for right-to-left display
  function automatic logic [20:0] mirror(input logic [20:0] c);
    case (c)
      21'h28:   return 21'h29;
      21'h29:   return 21'h28;
      21'h5B:   return 21'h5D;
      21'h5D:   return 21'h5B;
      21'h7B:   return 21'h7D;
      21'h7D:   return 21'h7B;
      21'h3C:   return 21'h3E;
      21'h3E:   return 21'h3C;
      21'h00AB: return 21'h00BB;
      21'h00BB: return 21'h00AB;
      default:  return c;
    endcase
  endfunction

  function automatic logic is_neutral(input cls_t t);
    return t == C_B || t == C_S || t == C_WS || t == C_ON || t == C_BN;
  endfunction

endpackage

>>> rtl/bidi_line_reorder_top.sv
// ----------------------------------------------------------------------------
// bidi_line_reorder_top: bidirectional line reordering
// Loads a logical text, resolves each line with simplified bidi rules and
// emits every character in visual order.
//
//   channel   signals                                   handshake
//   input     start, busy, codepoint, text_end          start && !busy
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//   result    result_valid, glyph, logical_index, ...   one-cycle strobe
//
// Loading accepts one request per cycle while busy is low. A request with
// text_end starts processing: each character is classified, then each
// line gets six sequential passes over the line memories and up to 2
// level scans with pairwise swaps for run reversal; then each result
// is emitted after a memory read of order, then text and level.
// busy stays high until the last result strobe. Reset is synchronous and
// clears the fill count, overflow flag and base_mode; no clearing pass.
// ----------------------------------------------------------------------------
module bidi_line_reorder_top #(
  parameter int MAX_CHARS = blr_pkg::MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [20:0] codepoint,
  input  logic        text_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        result_valid,
  output logic [20:0] glyph,
  output logic [5:0]  logical_index,
  output logic        is_rtl,
  output logic        base_is_rtl,
  output logic        overflowed,
  output logic        last_glyph
);
  import blr_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = !busy;

  // sequencer
  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .text_end (text_end),
    .st       (st),
    .cmd      (cmd),
    .busy     (busy)
  );

  // stores and rule logic
  blr_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .codepoint     (codepoint),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .st            (st),
    .result_valid  (result_valid),
    .glyph         (glyph),
    .logical_index (logical_index),
    .is_rtl        (is_rtl),
    .base_is_rtl   (base_is_rtl),
    .overflowed    (overflowed),
    .last_glyph    (last_glyph)
  );

`ifndef SYNTHESIS
  // results are never strobed back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("back-to-back result strobes");

  // a strobe while idle can only be the final result
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !busy |-> last_glyph)
    else $error("result strobe while idle that is not the last");

  // leaving processing coincides with the final result
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && last_glyph)
    else $error("processing ended without the final result");
`endif

endmodule

>>> rtl/blr_ctrl.sv
// ----------------------------------------------------------------------------
// blr_ctrl: phase sequencer
// Steps through loading, classification, the per-line rule passes,
// run reversal and output, driven by datapath status.
// ----------------------------------------------------------------------------
module blr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             text_end,
  input  blr_pkg::status_t st,
  output blr_pkg::cmd_t    cmd,
  output logic             busy
);
  import blr_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    busy       = (state != ST_LOAD);
    cmd.op     = state;
    cmd.accept = start && (state == ST_LOAD);
    case (state)
      ST_LOAD:     if (start && text_end) state_next = ST_CLS_RD;
      ST_CLS_RD:   state_next = ST_CLS_EX;
      ST_CLS_EX:   state_next = st.last_elem ? ST_BASE : ST_CLS_RD;
      ST_BASE:     state_next = ST_LINE;
      ST_LINE:     state_next = st.at_n ? ST_OUT_INIT : ST_FIND_RD;
      ST_FIND_RD:  state_next = st.at_n ? ST_W1_INIT : ST_FIND_EX;
      ST_FIND_EX:  state_next = st.is_b ? ST_W1_INIT : ST_FIND_RD;
      ST_W1_INIT:  state_next = st.empty ? ST_NL : ST_W1_RD;
      ST_W1_RD:    state_next = ST_W1_EX;
      ST_W1_EX:    state_next = st.hi_m1 ? ST_W4_INIT : ST_W1_RD;
      ST_W4_INIT:  state_next = ST_W4_RD;
      ST_W4_RD:    state_next = ST_W4_EX;
      ST_W4_EX:    state_next = st.at_hi ? ST_W5_INIT : ST_W4_RD;
      ST_W5_INIT:  state_next = ST_W5_RD;
      ST_W5_RD:    state_next = ST_W5_EX;
      ST_W5_EX:    state_next = st.lo_p1 ? ST_W7_INIT : ST_W5_RD;
      ST_W7_INIT:  state_next = ST_W7_RD;
      ST_W7_RD:    state_next = ST_W7_EX;
      ST_W7_EX:    state_next = st.hi_m1 ? ST_LV_INIT : ST_W7_RD;
      ST_LV_INIT:  state_next = ST_LV_RD;
      ST_LV_RD:    state_next = ST_LV_EX;
      ST_LV_EX:    state_next = st.lo_p1 ? ST_R_INIT : ST_LV_RD;
      ST_R_INIT:   state_next = st.hasodd ? ST_R_SRD : ST_NL;
      ST_R_SRD: begin
        if (st.at_hi) state_next = st.inrun ? ST_X1 : ST_LDONE;
        else          state_next = ST_R_SEX;
      end
      ST_R_SEX:    state_next = (!st.in_level && st.inrun) ? ST_X1 : ST_R_SRD;
      ST_X1:       state_next = st.swap_more ? ST_X2 : ST_R_SRD;
      ST_X2:       state_next = ST_X3;
      ST_X3:       state_next = ST_X4;
      ST_X4:       state_next = ST_X1;
      ST_LDONE:    state_next = st.lvl_one ? ST_NL : ST_R_SRD;
      ST_NL:       state_next = ST_LINE;
      ST_OUT_INIT: state_next = ST_O_RD1;
      ST_O_RD1:    state_next = ST_O_RD2;
      ST_O_RD2:    state_next = ST_O_EM;
      ST_O_EM:     state_next = st.last_elem ? ST_LOAD : ST_O_RD1;
      default:     state_next = ST_LOAD;
    endcase
  end

endmodule

>>> rtl/blr_dp.sv
// ----------------------------------------------------------------------------
// blr_dp: text stores and rule datapath
// Holds the text, class, level and visual order memories and the
// registers that carry context through each sequential pass.
// ----------------------------------------------------------------------------
module blr_dp #(
  parameter int MAX_CHARS = blr_pkg::MAX_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  blr_pkg::cmd_t    cmd,
  input  logic [20:0]      codepoint,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data,
  output blr_pkg::status_t st,
  output logic             result_valid,
  output logic [20:0]      glyph,
  output logic [5:0]       logical_index,
  output logic             is_rtl,
  output logic             base_is_rtl,
  output logic             overflowed,
  output logic             last_glyph
);
  import blr_pkg::*;

  localparam int AW = $clog2(MAX_CHARS);
  localparam int CW = $clog2(MAX_CHARS + 1);

  // memories
  logic [20:0]   text_mem [MAX_CHARS];
  cls_t          t_mem    [MAX_CHARS];
  cls_t          o_mem    [MAX_CHARS];
  logic [1:0]    lv_mem   [MAX_CHARS];
  logic [AW-1:0] vo_mem   [MAX_CHARS];

  logic [20:0]   text_q;
  cls_t          t_q, o_q;
  logic [1:0]    lv_q;
  logic [AW-1:0] vo_q;

  // control and context registers
  logic [CW-1:0] count, lo, hi, ptr, s, e;
  logic          ovf, found, first_rtl, base, carry, prevdir, right, flag;
  logic          hasodd, inrun;
  logic [1:0]    mode, maxl, lvl;
  cls_t          cur, p4, last, prevw1;
  logic [AW-1:0] sv, li;

  logic [CW-1:0] pm1, pp1;
  logic [AW-1:0] aw, awm1, em1;
  cls_t          sor, c_cls, w1v, w13, w4v, w5f, w5b, w6, w7v, w7w, rv;
  logic          neut, ldir, rdir, flag_n;
  logic [1:0]    lvv;

  // memory ports
  logic          text_we, t_we, o_we, lv_we, vo_we;
  logic [AW-1:0] text_ra, t_ra, lv_ra, vo_ra, t_wa, lv_wa, vo_wa;
  cls_t          t_wd;
  logic [1:0]    lv_wd;
  logic [AW-1:0] vo_wd;

  assign pm1  = ptr - 1'b1;
  assign pp1  = ptr + 1'b1;
  assign aw   = ptr[AW-1:0];
  assign awm1 = pm1[AW-1:0];
  assign em1  = AW'(e - 1'b1);
  assign sor  = base ? C_R : C_L;

  // status to the controller
  always_comb begin
    st.at_n      = (ptr == count);
    st.is_b      = (o_q == C_B);
    st.empty     = (lo == hi);
    st.at_hi     = (ptr == hi);
    st.hi_m1     = (pp1 == hi);
    st.lo_p1     = (ptr == CW'(lo + 1'b1));
    st.last_elem = (pp1 == count);
    st.hasodd    = hasodd;
    st.lvl_one   = (lvl == 2'd1);
    st.swap_more = (CW'(s + 1'b1) < e);
    st.inrun     = inrun;
    st.in_level  = (lv_q >= lvl);
  end

  // per-pass rule logic
  always_comb begin
    c_cls = classify(text_q);
    // W1 to W3
    w1v = (t_q == C_NSM) ? ((ptr == lo) ? sor : prevw1) : t_q;
    if (w1v == C_AL)                       w13 = C_R;
    else if (w1v == C_EN && last == C_AL)  w13 = C_AN;
    else                                   w13 = w1v;
    // W4 with right neighbor in t_q, then forward half of W5
    w4v = cur;
    if (ptr > CW'(lo + 1'b1) && ptr < hi) begin
      if (cur == C_ES && p4 == C_EN && t_q == C_EN) w4v = C_EN;
      else if (cur == C_CS && p4 == C_EN && t_q == C_EN) w4v = C_EN;
      else if (cur == C_CS && p4 == C_AN && t_q == C_AN) w4v = C_AN;
    end
    w5f = (w4v == C_ET && carry) ? C_EN : w4v;
    // backward half of W5, then W6
    w5b = (t_q == C_ET && carry) ? C_EN : t_q;
    w6  = (w5b == C_ES || w5b == C_ET || w5b == C_CS) ? C_ON : w5b;
    // W7 and left-side tag for neutrals
    w7v  = (t_q == C_EN && last == C_L) ? C_L : t_q;
    neut = is_neutral(w7v);
    w7w  = neut ? (prevdir ? C_NR : C_NL) : w7v;
    // N1/N2 with the right neighbor carried backward
    ldir = (t_q == C_NR);
    rdir = (ldir == right) ? ldir : base;
    if (t_q == C_NL || t_q == C_NR) rv = rdir ? C_R : C_L;
    else                            rv = t_q;
    // I1/I2
    if (base) begin
      lvv = (rv == C_L || rv == C_EN || rv == C_AN) ? 2'd2 : 2'd1;
    end else begin
      if (rv == C_R)                      lvv = 2'd1;
      else if (rv == C_EN || rv == C_AN)  lvv = 2'd2;
      else                                lvv = 2'd0;
    end
    // L1 separators and trailing whitespace
    flag_n = flag;
    if (o_q == C_S || o_q == C_B) begin
      lvv    = {1'b0, base};
      flag_n = 1'b1;
    end else if (o_q == C_WS || o_q == C_BN) begin
      if (flag) lvv = {1'b0, base};
    end else begin
      flag_n = 1'b0;
    end
  end

  // memory port selection
  always_comb begin
    text_we = cmd.accept && (count < CW'(MAX_CHARS));
    text_ra = (cmd.op == ST_O_RD2) ? vo_q : aw;
    t_ra    = (cmd.op == ST_W5_RD || cmd.op == ST_LV_RD) ? awm1 : aw;
    lv_ra   = (cmd.op == ST_O_RD2) ? vo_q : aw;
    case (cmd.op)
      ST_X1:   vo_ra = s[AW-1:0];
      ST_X2:   vo_ra = em1;
      default: vo_ra = aw;
    endcase
    t_we  = 1'b0;
    o_we  = 1'b0;
    t_wa  = aw;
    t_wd  = c_cls;
    lv_we = 1'b0;
    lv_wa = awm1;
    lv_wd = lvv;
    vo_we = 1'b0;
    vo_wa = awm1;
    vo_wd = awm1;
    case (cmd.op)
      ST_CLS_EX: begin
        t_we = 1'b1;
        o_we = 1'b1;
      end
      ST_W1_EX: begin
        t_we = 1'b1;
        t_wd = w13;
      end
      ST_W4_EX: begin
        t_we = (ptr != lo);
        t_wa = awm1;
        t_wd = w5f;
      end
      ST_W5_EX: begin
        t_we = 1'b1;
        t_wa = awm1;
        t_wd = w6;
      end
      ST_W7_EX: begin
        t_we = 1'b1;
        t_wd = w7w;
      end
      ST_LV_EX: begin
        lv_we = 1'b1;
        vo_we = 1'b1;
      end
      ST_X3: begin
        vo_we = 1'b1;
        vo_wa = s[AW-1:0];
        vo_wd = vo_q;
      end
      ST_X4: begin
        vo_we = 1'b1;
        vo_wa = em1;
        vo_wd = sv;
      end
      ST_NL: begin
        lv_we = (hi != count);
        lv_wa = hi[AW-1:0];
        lv_wd = {1'b0, base};
        vo_we = (hi != count);
        vo_wa = hi[AW-1:0];
        vo_wd = hi[AW-1:0];
      end
      default: ;
    endcase
  end

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (text_we) text_mem[count[AW-1:0]] <= codepoint;
    if (t_we)    t_mem[t_wa]  <= t_wd;
    if (o_we)    o_mem[aw]    <= c_cls;
    if (lv_we)   lv_mem[lv_wa] <= lv_wd;
    if (vo_we)   vo_mem[vo_wa] <= vo_wd;
    text_q <= text_mem[text_ra];
    t_q    <= t_mem[t_ra];
    o_q    <= o_mem[t_ra];
    lv_q   <= lv_mem[lv_ra];
    vo_q   <= vo_mem[vo_ra];
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      mode         <= MODE_AUTO;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.op == ST_O_EM);
      if (cfg_we) mode <= cfg_data;
      if (cmd.accept) begin
        if (count < CW'(MAX_CHARS)) count <= CW'(count + 1'b1);
        else                        ovf   <= 1'b1;
      end
      if (cmd.op == ST_O_EM && st.last_elem) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // pass registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ST_LOAD: begin
        ptr   <= '0;
        found <= 1'b0;
      end
      ST_CLS_EX: begin
        if (!found && (c_cls == C_L || c_cls == C_R || c_cls == C_AL)) begin
          found     <= 1'b1;
          first_rtl <= (c_cls != C_L);
        end
        ptr <= pp1;
      end
      ST_BASE: begin
        if (mode == MODE_LTR)      base <= 1'b0;
        else if (mode == MODE_RTL) base <= 1'b1;
        else                       base <= found && first_rtl;
        ptr <= '0;
      end
      ST_LINE:    lo <= ptr;
      ST_FIND_RD: if (ptr == count) hi <= ptr;
      ST_FIND_EX: begin
        if (o_q == C_B) hi  <= ptr;
        else            ptr <= pp1;
      end
      ST_W1_INIT: begin
        ptr  <= lo;
        last <= sor;
      end
      ST_W1_EX: begin
        prevw1 <= w1v;
        if (w1v == C_L || w1v == C_R || w1v == C_AL) last <= w1v;
        ptr <= pp1;
      end
      ST_W4_INIT: begin
        ptr   <= lo;
        carry <= 1'b0;
      end
      ST_W4_EX: begin
        if (ptr != lo) begin
          p4    <= w4v;
          carry <= (w5f == C_EN);
        end
        cur <= t_q;
        ptr <= pp1;
      end
      ST_W5_INIT: begin
        ptr   <= hi;
        carry <= 1'b0;
      end
      ST_W5_EX: begin
        if (t_q != C_ET) carry <= (t_q == C_EN);
        ptr <= pm1;
      end
      ST_W7_INIT: begin
        ptr     <= lo;
        last    <= sor;
        prevdir <= base;
      end
      ST_W7_EX: begin
        if (t_q == C_L || t_q == C_R) last <= t_q;
        if (!neut) prevdir <= (w7v != C_L);
        ptr <= pp1;
      end
      ST_LV_INIT: begin
        ptr    <= hi;
        right  <= base;
        flag   <= 1'b1;
        maxl   <= 2'd0;
        hasodd <= 1'b0;
      end
      ST_LV_EX: begin
        if (t_q != C_NL && t_q != C_NR) right <= (t_q != C_L);
        flag <= flag_n;
        if (lvv > maxl) maxl <= lvv;
        if (lvv[0]) hasodd <= 1'b1;
        ptr <= pm1;
      end
      ST_R_INIT: begin
        lvl   <= maxl;
        ptr   <= lo;
        inrun <= 1'b0;
      end
      ST_R_SRD: begin
        if (ptr == hi && inrun) begin
          e     <= ptr;
          inrun <= 1'b0;
        end
      end
      ST_R_SEX: begin
        if (lv_q >= lvl) begin
          if (!inrun) begin
            s     <= ptr;
            inrun <= 1'b1;
          end
        end else if (inrun) begin
          e     <= ptr;
          inrun <= 1'b0;
        end
        ptr <= pp1;
      end
      ST_X2: sv <= vo_q;
      ST_X4: begin
        s <= CW'(s + 1'b1);
        e <= CW'(e - 1'b1);
      end
      ST_LDONE: begin
        lvl <= lvl - 2'd1;
        ptr <= lo;
      end
      ST_NL:       ptr <= (hi != count) ? CW'(hi + 1'b1) : hi;
      ST_OUT_INIT: ptr <= '0;
      ST_O_RD2:    li  <= vo_q;
      ST_O_EM: begin
        glyph         <= lv_q[0] ? mirror(text_q) : text_q;
        logical_index <= 6'(li);
        is_rtl        <= lv_q[0];
        base_is_rtl   <= base;
        overflowed    <= ovf;
        last_glyph    <= st.last_elem;
        ptr           <= pp1;
      end
      default: ;
    endcase
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the bidi line reorder block
// Loads texts one codepoint per request, predicts the visual order, levels,
// mirrored glyphs and flags of each text, and compares every result strobe
// with the oldest prediction. Covers all base modes, overflow and mixed text.
// ----------------------------------------------------------------------------
module tb_top;
  import blr_pkg::*;

  localparam int NCH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [20:0] glyph;
    logic [5:0]  lidx;
    logic        rtl;
    logic        base_rtl;
    logic        ovf;
    logic        last;
  } glyph_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [20:0] codepoint = '0;
  logic        text_end = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        result_valid;
  logic [20:0] glyph;
  logic [5:0]  logical_index;
  logic        is_rtl;
  logic        base_is_rtl;
  logic        overflowed;
  logic        last_glyph;

  bidi_line_reorder_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .codepoint(codepoint), .text_end(text_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .glyph(glyph), .logical_index(logical_index),
    .is_rtl(is_rtl), .base_is_rtl(base_is_rtl), .overflowed(overflowed),
    .last_glyph(last_glyph)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [20:0] txt [NCH];
  cls_t        cls [NCH];
  cls_t        ocls [NCH];
  logic [1:0]  lvl [NCH];
  logic [5:0]  vord [NCH];
  int          fill_cnt;
  logic        drop_flag;
  logic [1:0]  mode_reg;

  glyph_res_t  expected_glyphs [$];
  int          err_cnt;
  int          cycle_cnt;
  int          idle_pct;

  // mismatch report
  task automatic report_err(input string what);
    $display("ERROR t=%0t %s", $time, what);
    err_cnt++;
  endtask

  function automatic logic dir_r(input cls_t t);
    return t != C_L;
  endfunction

  function automatic logic neut(input cls_t t);
    return t == C_B || t == C_S || t == C_WS || t == C_ON || t == C_BN;
  endfunction

  function automatic logic [20:0] flip_glyph(input logic [20:0] c);
    case (c)
      21'h28: return 21'h29;
      21'h29: return 21'h28;
      21'h5B: return 21'h5D;
      21'h5D: return 21'h5B;
      21'h7B: return 21'h7D;
      21'h7D: return 21'h7B;
      21'h3C: return 21'h3E;
      21'h3E: return 21'h3C;
      21'hAB: return 21'hBB;
      21'hBB: return 21'hAB;
      default: return c;
    endcase
  endfunction

  function automatic cls_t class_of(input logic [20:0] c);
    if (c == 21'h0A) return C_B;
    if (c == 21'h09) return C_S;
    if (c == 21'h20) return C_WS;
    if (c == 21'hA0) return C_CS;
    if (c == 21'h200E) return C_L;
    if (c == 21'h200F) return C_R;
    if (c == 21'h200C || c == 21'h200D) return C_BN;
    if (c >= 21'h30 && c <= 21'h39) return C_EN;
    if (c == 21'h2B || c == 21'h2D) return C_ES;
    if (c >= 21'h23 && c <= 21'h25) return C_ET;
    if (c == 21'h2C || c == 21'h2E || c == 21'h3A || c == 21'h2F) return C_CS;
    if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)) return C_L;
    if (c >= 21'h591 && c <= 21'h5BD) return C_NSM;
    if (c == 21'h5BF || c == 21'h5C1 || c == 21'h5C2 || c == 21'h5C4 ||
        c == 21'h5C5 || c == 21'h5C7) return C_NSM;
    if (c >= 21'h590 && c <= 21'h5FF) return C_R;
    if (c >= 21'h660 && c <= 21'h669) return C_AN;
    if (c >= 21'h600 && c <= 21'h6FF) return C_AL;
    if (c >= 21'h750 && c <= 21'h77F) return C_AL;
    if (c < 21'h80) return C_ON;
    return C_L;
  endfunction

  // resolve one line [lo,hi) and build its visual order
  task automatic resolve_span(input int lo, input int hi, input logic para);
    cls_t sor, prev, lft, rgt, res;
    int k, a, m, s, e, l, maxl, minodd;
    logic touch;
    logic [5:0] tmp;
    sor = para ? C_R : C_L;
    if (hi <= lo) return;
    for (k = lo; k < hi; k++)
      if (cls[k] == C_NSM) cls[k] = (k == lo) ? sor : cls[k-1];
    prev = sor;
    for (k = lo; k < hi; k++) begin
      if (cls[k] == C_L || cls[k] == C_R || cls[k] == C_AL) prev = cls[k];
      else if (cls[k] == C_EN && prev == C_AL) cls[k] = C_AN;
    end
    for (k = lo; k < hi; k++) if (cls[k] == C_AL) cls[k] = C_R;
    for (k = lo + 1; k + 1 < hi; k++) begin
      if (cls[k] == C_ES && cls[k-1] == C_EN && cls[k+1] == C_EN) cls[k] = C_EN;
      else if (cls[k] == C_CS && cls[k-1] == C_EN && cls[k+1] == C_EN) cls[k] = C_EN;
      else if (cls[k] == C_CS && cls[k-1] == C_AN && cls[k+1] == C_AN) cls[k] = C_AN;
    end
    k = lo;
    while (k < hi) begin
      if (cls[k] != C_ET) begin
        k++;
      end else begin
        a = k;
        while (k < hi && cls[k] == C_ET) k++;
        touch = (a > lo && cls[a-1] == C_EN) || (k < hi && cls[k] == C_EN);
        if (touch) for (m = a; m < k; m++) cls[m] = C_EN;
      end
    end
    for (k = lo; k < hi; k++)
      if (cls[k] == C_ES || cls[k] == C_ET || cls[k] == C_CS) cls[k] = C_ON;
    prev = sor;
    for (k = lo; k < hi; k++) begin
      if (cls[k] == C_L || cls[k] == C_R) prev = cls[k];
      else if (cls[k] == C_EN && prev == C_L) cls[k] = C_L;
    end
    k = lo;
    while (k < hi) begin
      if (!neut(cls[k])) begin
        k++;
      end else begin
        a = k;
        while (k < hi && neut(cls[k])) k++;
        lft = (a == lo) ? sor : (dir_r(cls[a-1]) ? C_R : C_L);
        rgt = (k == hi) ? sor : (dir_r(cls[k]) ? C_R : C_L);
        res = (lft == rgt) ? lft : sor;
        for (m = a; m < k; m++) cls[m] = res;
      end
    end
    for (k = lo; k < hi; k++) begin
      lvl[k] = {1'b0, para};
      if (!para) begin
        if (cls[k] == C_R) lvl[k] = 2'd1;
        else if (cls[k] == C_EN || cls[k] == C_AN) lvl[k] = 2'd2;
      end else if (cls[k] == C_L || cls[k] == C_EN || cls[k] == C_AN) begin
        lvl[k] = 2'd2;
      end
    end
    // trailing whitespace takes the paragraph level
    for (k = hi; k > lo; k--) begin
      if (ocls[k-1] == C_WS || ocls[k-1] == C_BN || ocls[k-1] == C_S ||
          ocls[k-1] == C_B) lvl[k-1] = {1'b0, para};
      else break;
    end
    for (k = lo; k < hi; k++)
      if (ocls[k] == C_S || ocls[k] == C_B) begin
        lvl[k] = {1'b0, para};
        for (m = k; m > lo && (ocls[m-1] == C_WS || ocls[m-1] == C_BN); m--)
          lvl[m-1] = {1'b0, para};
      end
    maxl = 0;
    minodd = 4;
    for (k = lo; k < hi; k++) begin
      vord[k] = k[5:0];
      if (lvl[k] > maxl) maxl = lvl[k];
      if (lvl[k][0] && lvl[k] < minodd) minodd = lvl[k];
    end
    // run reversal from the highest level down
    for (l = maxl; l >= minodd; l--) begin
      k = lo;
      while (k < hi) begin
        if (lvl[k] >= l) begin
          s = k;
          while (k < hi && lvl[k] >= l) k++;
          e = k;
          while (s + 1 < e) begin
            tmp = vord[s];
            vord[s] = vord[e-1];
            vord[e-1] = tmp;
            s++;
            e--;
          end
        end else begin
          k++;
        end
      end
    end
  endtask

  // load one codepoint into the predictor; on text end queue the results
  task automatic predict_text(input logic [20:0] cp, input logic fin);
    int n, k, i, j, li;
    logic base;
    glyph_res_t r;
    if (fill_cnt < NCH) begin
      txt[fill_cnt] = cp;
      fill_cnt++;
    end else begin
      drop_flag = 1'b1;
    end
    if (!fin) return;
    n = fill_cnt;
    for (k = 0; k < n; k++) begin
      cls[k] = class_of(txt[k]);
      ocls[k] = cls[k];
    end
    base = 1'b0;
    if (mode_reg == MODE_LTR) base = 1'b0;
    else if (mode_reg == MODE_RTL) base = 1'b1;
    else
      for (k = 0; k < n; k++) begin
        if (ocls[k] == C_L) break;
        if (ocls[k] == C_R || ocls[k] == C_AL) begin
          base = 1'b1;
          break;
        end
      end
    i = 0;
    while (i < n) begin
      j = i;
      while (j < n && txt[j] != 21'h0A) j++;
      resolve_span(i, j, base);
      if (j < n) begin
        vord[j] = j[5:0];
        lvl[j] = {1'b0, base};
        j++;
      end
      i = j;
    end
    for (k = 0; k < n; k++) begin
      li = vord[k];
      r.rtl = lvl[li][0];
      r.glyph = r.rtl ? flip_glyph(txt[li]) : txt[li];
      r.lidx = li[5:0];
      r.base_rtl = base;
      r.ovf = drop_flag;
      r.last = (k + 1 == n);
      expected_glyphs = {expected_glyphs, r};
    end
    fill_cnt = 0;
    drop_flag = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    glyph_res_t exp_r;
    if (!rst && result_valid) begin
      if (expected_glyphs.size() == 0) begin
        report_err("result with no prediction pending");
      end else begin
        exp_r = expected_glyphs.pop_front();
        if (glyph !== exp_r.glyph)
          report_err($sformatf("glyph %h exp %h", glyph, exp_r.glyph));
        if (logical_index !== exp_r.lidx)
          report_err($sformatf("logical_index %0d exp %0d", logical_index, exp_r.lidx));
        if (is_rtl !== exp_r.rtl)
          report_err($sformatf("is_rtl %b exp %b idx %0d", is_rtl, exp_r.rtl, exp_r.lidx));
        if (base_is_rtl !== exp_r.base_rtl)
          report_err($sformatf("base_is_rtl %b exp %b", base_is_rtl, exp_r.base_rtl));
        if (overflowed !== exp_r.ovf)
          report_err($sformatf("overflowed %b exp %b", overflowed, exp_r.ovf));
        if (last_glyph !== exp_r.last)
          report_err($sformatf("last_glyph %b exp %b", last_glyph, exp_r.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // send one request, with a random gap before it
  task automatic send_char(input logic [20:0] cp, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    codepoint <= cp;
    text_end <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_text(cp, fin);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (expected_glyphs.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_reg = m;
  endtask

  function automatic logic [20:0] rand_cp();
    int sel;
    sel = int'($urandom_range(15));
    case (sel)
      0: return 21'h0A;
      1: return 21'($urandom_range(21'h39, 21'h30));
      2: return 21'($urandom_range(21'h7F, 21'h20));
      3, 4: return 21'($urandom_range(21'h5A, 21'h41));
      5, 6: return 21'($urandom_range(21'h5EA, 21'h5D0));
      7: return 21'($urandom_range(21'h5C7, 21'h591));
      8: return 21'($urandom_range(21'h6FF, 21'h600));
      9: return 21'($urandom_range(21'h669, 21'h660));
      10: return 21'($urandom_range(21'h77F, 21'h750));
      11: begin
        sel = int'($urandom_range(7));
        case (sel)
          0: return 21'h09;
          1: return 21'hA0;
          2: return 21'h200E;
          3: return 21'h200F;
          4: return 21'h200C;
          5: return 21'h200D;
          6: return 21'hAB;
          default: return 21'hBB;
        endcase
      end
      12: return 21'($urandom_range(21'h29, 21'h28));
      13: return {1'($urandom_range(1)), 20'($urandom_range(21'hFFFFF))};
      14: return 21'h1FFFFF;
      default: return 21'h20;
    endcase
  endfunction

  // send a text of the given length with random content
  task automatic send_text(input int len);
    int k;
    for (k = 0; k < len; k++) send_char(rand_cp(), k == len - 1);
  endtask

  task automatic test_directed();
    logic [20:0] seq [$];
    int k;
    write_mode(MODE_AUTO);
    // mixed text with digits, brackets, marks and a newline
    seq = '{21'h5D0, 21'h20, 21'h28, 21'h31, 21'h2E, 21'h32, 21'h29, 21'h591,
            21'h0A, 21'h61, 21'h20, 21'h665, 21'h2C, 21'h666, 21'h24, 21'h09,
            21'h620, 21'h33, 21'h2B, 21'h34, 21'hAB, 21'h1FFFFF, 21'h0, 21'h20};
    for (k = 0; k < seq.size(); k++) send_char(seq[k], k == seq.size() - 1);
    // single character, no strong character
    send_char(21'h0A, 1'b1);
    send_char(21'h31, 1'b1);
  endtask

  task automatic test_modes();
    write_mode(MODE_RTL);
    send_text(12);
    wait_drain();
    write_mode(MODE_LTR);
    send_text(12);
    wait_drain();
    write_mode(2'd3);
    send_text(10);
    wait_drain();
    write_mode(MODE_AUTO);
  endtask

  // more than the store holds, end on a dropped codepoint
  task automatic test_overflow();
    send_text(NCH + 3);
    wait_drain();
    send_text(NCH);
  endtask

  task automatic test_random(input int items);
    int sent, len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9) == 0) ? int'($urandom_range(70, 40)) :
                                       int'($urandom_range(10, 1));
      send_text(len);
      sent += len;
      if ($urandom_range(7) == 0) begin
        wait_drain();
        write_mode(2'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    fill_cnt = 0;
    drop_flag = 1'b0;
    mode_reg = MODE_AUTO;
    err_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 14;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drain();
    test_modes();
    test_overflow();
    wait_drain();
    test_random(35);
    wait_drain();
    idle_pct = 46;
    test_random(35);
    wait_drain();
    idle_pct = 0;
    test_random(35);
    wait_drain();
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && expected_glyphs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/blr_pkg.sv
rtl/blr_ctrl.sv
rtl/blr_dp.sv
rtl/bidi_line_reorder_top.sv
sim/tb_top.sv
